@@ hw/rtl/b64d_pkg.sv @@
package b64d_pkg;

	// character item
	typedef struct packed {
		logic [7:0] char_in;
		logic       final_char;
	} chr_item_t;

	// result item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_status;
		logic       decode_ok;
		logic       end_of_run;
	} res_item_t;

	// decoder state
	typedef struct packed {
		logic [17:0] accum;
		logic [1:0]  gpos;
		logic [1:0]  pad;
		logic        err;
	} dec_state_t;

	// results caused by one item: bytes first, then the optional status
	typedef struct packed {
		logic [0:2][7:0] bytes;
		logic [1:0]      nbytes;
		logic            status;
		logic            ok;
	} dec_bundle_t;

	typedef enum logic [1:0] {
		SYM_DATA,
		SYM_PAD,
		SYM_BAD
	} sym_kind_t;

	typedef struct packed {
		sym_kind_t  kind;
		logic [5:0] value;
	} sym_t;

	localparam logic [5:0] SEXTET_LOWER = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT = 6'd52;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [7:0] CHAR_PAD     = 8'h3D;
	localparam logic [1:0] GPOS_LAST    = 2'd3;
	localparam logic [1:0] GPOS_FIRST_PAD = 2'd2;
	localparam logic [1:0] PAD_MAX      = 2'd2;

	function automatic sym_t classify(input logic [7:0] c);
		sym_t s;
		logic [7:0] d;
		s.kind  = SYM_BAD;
		s.value = '0;
		d       = '0;
		if (c >= "A" && c <= "Z") begin
			d       = c - 8'("A");
			s.kind  = SYM_DATA;
			s.value = d[5:0];
		end else if (c >= "a" && c <= "z") begin
			d       = c - 8'("a");
			s.kind  = SYM_DATA;
			s.value = SEXTET_LOWER + d[5:0];
		end else if (c >= "0" && c <= "9") begin
			d       = c - 8'("0");
			s.kind  = SYM_DATA;
			s.value = SEXTET_DIGIT + d[5:0];
		end else if (c == 8'("+")) begin
			s.kind  = SYM_DATA;
			s.value = SEXTET_PLUS;
		end else if (c == 8'("/")) begin
			s.kind  = SYM_DATA;
			s.value = SEXTET_SLASH;
		end else if (c == CHAR_PAD) begin
			s.kind  = SYM_PAD;
		end
		return s;
	endfunction

endpackage

@@ hw/rtl/b64d_decode.sv @@
module b64d_decode (
	input  b64d_pkg::chr_item_t   item,
	input  b64d_pkg::dec_state_t  cur,
	output b64d_pkg::dec_state_t  nxt,
	output b64d_pkg::dec_bundle_t bnd
);
	import b64d_pkg::*;

	sym_t        sym;
	logic        bad;
	logic        err_new;
	logic [1:0]  pad_new;
	logic [5:0]  val;
	logic [23:0] full;
	logic [1:0]  pad_eff;

	always_comb begin
		sym     = classify(item.char_in);
		bad     = 1'b0;
		pad_new = cur.pad;
		val     = '0;
		unique case (sym.kind)
			SYM_BAD: bad = 1'b1;
			SYM_PAD: begin
				if (cur.gpos < GPOS_FIRST_PAD) bad = 1'b1;
				else pad_new = cur.pad + 2'd1;
			end
			SYM_DATA: begin
				if (cur.pad != 2'd0) bad = 1'b1;
				val = sym.value;
			end
			default: bad = 1'b1;
		endcase
		if (item.final_char && cur.gpos != GPOS_LAST) bad = 1'b1;

		full    = {cur.accum, val};
		pad_eff = (pad_new > PAD_MAX) ? PAD_MAX : pad_new;
		err_new = cur.err | bad;

		nxt        = cur;
		bnd.bytes  = {full[23:16], full[15:8], full[7:0]};
		bnd.nbytes = 2'd0;
		bnd.status = item.final_char;
		bnd.ok     = !err_new;

		if (!cur.err) begin
			if (bad) begin
				nxt.err = 1'b1;
			end else begin
				nxt.pad = pad_new;
				if (cur.gpos == GPOS_LAST) begin
					bnd.nbytes = 2'd3 - pad_eff;
					nxt.accum  = '0;
					nxt.gpos   = '0;
				end else begin
					nxt.accum = full[17:0];
					nxt.gpos  = cur.gpos + 2'd1;
				end
			end
		end

		// end of string: start over
		if (item.final_char) nxt = '0;
	end

endmodule

@@ hw/rtl/base64_decoder.sv @@
// Streaming Base64 decoder, standard alphabet with '=' padding.
//
// Character channel (chr_*): one encoded character per item, final_char
// set on the last character of a string. Result channel (res_*): decoded
// bytes one per item, and after the last character a status item
// (is_status = 1, decode_ok = 1 when the whole string was well formed).
// end_of_run marks the last result caused by a character.
//
// A character passes through the input register and then the result register,
// which offers its first result. The decoder takes one character per cycle
// while chr_stall is low. A character that ends a group may cause up to four
// results, which leave one per cycle from the result register while res_stall
// is low; the characters that follow keep flowing as long as they cause no
// results, so with res_stall low a steady stream of four characters per
// three bytes runs at one character per cycle. chr_stall rises only when a
// character with results waits for the result register to drain.
//
// After a decode error no data bytes are sent; the consumer drops the
// bytes of that string already received. Reset clears the decoder state and
// both pipeline valid flags; res_stall simply holds the current result.
module base64_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                chr_valid,
	output logic                chr_stall,
	input  b64d_pkg::chr_item_t chr_item,
	output logic                res_valid,
	input  logic                res_stall,
	output b64d_pkg::res_item_t res_item
);
	import b64d_pkg::*;

	// input register
	chr_item_t   chr_s1;
	logic        vld_s1;

	// decoder state
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_bundle_t bnd;

	// result register: bundle and read index
	dec_bundle_t bnd_s2;
	logic        vld_s2;
	logic [1:0]  last_s2;
	logic [1:0]  idx_q;

	logic        emit;
	logic        s2_free;
	logic        adv;
	logic [2:0]  total;

	b64d_decode u_decode (
		.item (chr_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.bnd  (bnd)
	);

	assign emit    = (bnd.nbytes != 2'd0) || bnd.status;
	// result register empties this cycle or is already empty
	assign s2_free = !vld_s2 || (!res_stall && idx_q == last_s2);
	assign adv     = vld_s1 && (!emit || s2_free);
	assign chr_stall = vld_s1 && !adv;
	assign total   = {1'b0, bnd.nbytes} + {2'b00, bnd.status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!chr_stall) begin
			vld_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_valid && !chr_stall) begin
			chr_s1 <= chr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			idx_q  <= '0;
		end else if (adv && emit) begin
			vld_s2 <= 1'b1;
			idx_q  <= '0;
		end else if (vld_s2 && !res_stall) begin
			if (idx_q == last_s2) vld_s2 <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			bnd_s2  <= bnd;
			last_s2 <= 2'(total - 3'd1);
		end
	end

	// current result: bytes first, status last
	always_comb begin
		res_valid           = vld_s2;
		res_item.end_of_run = (idx_q == last_s2);
		if (idx_q < bnd_s2.nbytes) begin
			res_item.data_byte = bnd_s2.bytes[idx_q];
			res_item.is_status = 1'b0;
			res_item.decode_ok = 1'b0;
		end else begin
			res_item.data_byte = '0;
			res_item.is_status = 1'b1;
			res_item.decode_ok = bnd_s2.ok;
		end
	end

endmodule

@@ hw/rtl/b64d_checker.sv @@
module b64d_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                chr_valid,
	input logic                chr_stall,
	input b64d_pkg::chr_item_t chr_item,
	input logic                res_valid,
	input logic                res_stall,
	input b64d_pkg::res_item_t res_item
);
	import b64d_pkg::*;

	// held result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// status always closes the run of a character
	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.is_status |-> res_item.end_of_run)
		else $error("status result without end_of_run");

	// data results never claim success
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.is_status |-> !res_item.decode_ok)
		else $error("data result with decode_ok set");

	// input backpressure only while results are pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		chr_stall |-> res_valid)
		else $error("character stalled with no result pending");

	// a stalled character stays offered unchanged
	a_chr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr_stall |=> chr_valid && $stable(chr_item))
		else $error("character changed while stalled");

endmodule

bind base64_decoder b64d_checker u_b64d_checker (.*);
